FILE: sv/ntm_pkg.sv
// ----------------------------------------------------------------------------
// ntm_pkg
// Shared sizes, codes and sequencer states of the nearest track matcher.
// ----------------------------------------------------------------------------
package ntm_pkg;

    localparam int MAX_TRACKS    = 32;
    localparam int HIST_DEPTH    = 5;
    localparam int COORD_BITS    = 12;

    localparam int TRK_BITS      = $clog2(MAX_TRACKS);
    localparam int LIVE_BITS     = $clog2(MAX_TRACKS + 1);
    localparam int HD_BITS       = $clog2(HIST_DEPTH);
    localparam int LEN_BITS      = $clog2(HIST_DEPTH + 1);
    localparam int HADDR_BITS    = $clog2(MAX_TRACKS * HIST_DEPTH);
    localparam int PRED_BITS     = COORD_BITS + 2;
    localparam int DIFF_BITS     = COORD_BITS + 3;
    localparam int SQ_BITS       = 2 * (DIFF_BITS - 1);
    localparam int THR_BITS      = SQ_BITS + 1;
    localparam int ACC_BITS      = COORD_BITS + LEN_BITS;
    localparam int SUM_BITS      = ACC_BITS + 1;
    localparam int NUM_BITS      = ACC_BITS;
    localparam int DIV_CNT_BITS  = $clog2(NUM_BITS + 1);
    localparam int WSUM_MAX      = HIST_DEPTH * (HIST_DEPTH - 1) / 2;
    localparam int DEN_BITS      = $clog2(WSUM_MAX + 1);
    localparam int MISS_BITS     = 4;
    localparam int KIND_BITS     = 2;
    localparam int IDX_OUT_BITS  = 5;
    localparam int LIVE_OUT_BITS = 6;

    localparam logic [MISS_BITS-1:0] MISS_MAX         = '1;
    localparam logic [MISS_BITS-1:0] MISS_LIMIT_RESET = 4'd5;

    localparam logic [KIND_BITS-1:0] KIND_FRAME_START = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DETECTION   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_FRAME_END   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_SCAN,
        S_P_ADDR,
        S_P_ACC,
        S_P_DIV_GO,
        S_P_DIV_WAIT,
        S_P_WRITE,
        S_D_W,
        S_D_H,
        S_D_THR,
        S_D_SCAN,
        S_D_EX,
        S_D_EY,
        S_D_CMP,
        S_D_DECIDE,
        S_E_SCAN,
        S_FINISH
    } state_t;

endpackage

FILE: sv/ntm_squarer.sv
// ----------------------------------------------------------------------------
// ntm_squarer
// Shared registered squarer for box sizes and distance components.
// ----------------------------------------------------------------------------
module ntm_squarer
    import ntm_pkg::*;
(
    input  logic                       clk,
    input  logic signed [DIFF_BITS-1:0] op,
    output logic [SQ_BITS-1:0]         sq
);

    logic [DIFF_BITS-2:0] mag;
    logic [SQ_BITS-1:0]   sq_reg;

    always_comb
    begin
        if (op[DIFF_BITS-1])
        begin
            mag = (DIFF_BITS-1)'(-op);
        end
        else
        begin
            mag = op[DIFF_BITS-2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= SQ_BITS'(mag) * SQ_BITS'(mag);
    end

    assign sq = sq_reg;

endmodule

FILE: sv/ntm_divider.sv
// ----------------------------------------------------------------------------
// ntm_divider
// Two-lane restoring divider, one quotient bit per lane and cycle.
// ----------------------------------------------------------------------------
module ntm_divider
    import ntm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_BITS-1:0]  num_x,
    input  logic [NUM_BITS-1:0]  num_y,
    input  logic [DEN_BITS-1:0]  den,
    output logic                 done,
    output logic [NUM_BITS-1:0]  quo_x,
    output logic [NUM_BITS-1:0]  quo_y
);

    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS-1:0] rem_x_reg, rem_y_reg, rem_x_next, rem_y_next;
    logic [NUM_BITS-1:0] q_x_reg, q_y_reg, q_x_next, q_y_next;

    function automatic logic [DEN_BITS+NUM_BITS-1:0] div_step(
        input logic [DEN_BITS-1:0] rem,
        input logic [NUM_BITS-1:0] q,
        input logic [DEN_BITS-1:0] d
    );
        logic [DEN_BITS:0]   shifted;
        logic [DEN_BITS-1:0] rem_n;
        logic                qbit;
        shifted = {rem, q[NUM_BITS-1]};
        if (shifted >= (DEN_BITS+1)'(d))
        begin
            rem_n = DEN_BITS'(shifted - (DEN_BITS+1)'(d));
            qbit  = 1'b1;
        end
        else
        begin
            rem_n = shifted[DEN_BITS-1:0];
            qbit  = 1'b0;
        end
        div_step = {rem_n, q[NUM_BITS-2:0], qbit};
    endfunction

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        q_x_next   = q_x_reg;
        q_y_next   = q_y_reg;
        if (start)
        begin
            cnt_next   = DIV_CNT_BITS'(NUM_BITS);
            rem_x_next = '0;
            rem_y_next = '0;
            q_x_next   = num_x;
            q_y_next   = num_y;
        end
        else if (cnt_reg != '0)
        begin
            {rem_x_next, q_x_next} = div_step(rem_x_reg, q_x_reg, den_reg);
            {rem_y_next, q_y_next} = div_step(rem_y_reg, q_y_reg, den_reg);
            cnt_next  = cnt_reg - DIV_CNT_BITS'(1);
            done_next = (cnt_reg == DIV_CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        q_x_reg   <= q_x_next;
        q_y_reg   <= q_y_next;
    end

    assign done  = done_reg;
    assign quo_x = q_x_reg;
    assign quo_y = q_y_reg;

endmodule

FILE: sv/nearest_track_matcher.sv
// ----------------------------------------------------------------------------
// nearest_track_matcher
// Nearest-neighbor tracker: track table, sequencer, history and prediction.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low, and exactly one result
// word follows on the done strobe, one cycle wide, which cannot be held off.
// Busy drops in the cycle done is high, so the next word may start there.
// A frame end visits every slot in turn. A detection squares the box width
// and height, then scans the slots, the shared squarer working each live
// track's x and y distance in turn. A frame start scans the slots and, for a
// live track with n centers, reads them one by one through the single read
// port of the history memory, then runs the serial divider when n is above
// one.
// ----------------------------------------------------------------------------
module nearest_track_matcher
    import ntm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [KIND_BITS-1:0]      kind,
    input  logic [COORD_BITS-1:0]     center_x,
    input  logic [COORD_BITS-1:0]     center_y,
    input  logic [COORD_BITS-1:0]     box_width,
    input  logic [COORD_BITS-1:0]     box_height,
    input  logic                      miss_limit_we,
    input  logic [MISS_BITS-1:0]      miss_limit_data,
    output logic                      done,
    output logic [IDX_OUT_BITS-1:0]   track_index,
    output logic                      is_new,
    output logic                      dropped,
    output logic [LIVE_OUT_BITS-1:0]  live_tracks,
    output logic [LIVE_OUT_BITS-1:0]  removed_count
);

    state_t state_reg, state_next;

    logic [TRK_BITS-1:0]   t_reg;
    logic                  done_reg;
    logic [MISS_BITS-1:0]  miss_limit_reg;
    logic                  valid_reg   [MAX_TRACKS];
    logic [LEN_BITS-1:0]   len_reg     [MAX_TRACKS];
    logic                  matched_reg [MAX_TRACKS];
    logic [MISS_BITS-1:0]  miss_reg    [MAX_TRACKS];
    logic [HD_BITS-1:0]    head_reg    [MAX_TRACKS];
    logic [LIVE_BITS-1:0]  live_reg;
    logic                  best_found_reg;
    logic                  free_found_reg;

    logic [COORD_BITS-1:0] cx_reg, cy_reg, w_reg, h_reg;
    logic [LEN_BITS-1:0]   n_reg, j_reg;
    logic [ACC_BITS-1:0]   acc_x_reg, acc_y_reg;
    logic [COORD_BITS-1:0] c0x_reg, c0y_reg;
    logic                  negx_reg, negy_reg;
    logic [THR_BITS-1:0]   thr_reg;
    logic [SQ_BITS-1:0]    dx2_reg;
    logic signed [DIFF_BITS-1:0] ey_reg;
    logic [THR_BITS-1:0]   best_reg;
    logic [TRK_BITS-1:0]   best_t_reg, free_t_reg;
    logic [TRK_BITS-1:0]   idx_out_reg;
    logic                  new_out_reg, drop_out_reg;
    logic [LIVE_BITS-1:0]  removed_reg;

    logic [2*COORD_BITS-1:0] hist_mem [MAX_TRACKS*HIST_DEPTH];
    logic [2*COORD_BITS-1:0] hist_rd_reg;
    logic [2*PRED_BITS-1:0]  pred_mem [MAX_TRACKS];
    logic [2*PRED_BITS-1:0]  pred_rd_reg;

    logic                    hist_we;
    logic [HADDR_BITS-1:0]   hist_waddr, hist_raddr;
    logic [2*COORD_BITS-1:0] hist_wdata;
    logic                    pred_we;
    logic [TRK_BITS-1:0]     pred_waddr, pred_raddr;
    logic [2*PRED_BITS-1:0]  pred_wdata;

    logic signed [DIFF_BITS-1:0] sq_op;
    logic [SQ_BITS-1:0]          sq;
    logic                        div_start, div_done;
    logic [NUM_BITS-1:0]         div_num_x, div_num_y, quo_x, quo_y;
    logic [DEN_BITS-1:0]         div_den;

    logic                  accept;
    logic                  t_last, t_inc;
    logic                  cur_valid, cur_miss;
    logic [MISS_BITS-1:0]  miss_inc;
    logic                  cur_free;
    logic [THR_BITS-1:0]   d2;
    logic                  better;
    logic                  match_now, open_now;
    logic [HD_BITS-1:0]    push_head;
    logic signed [SUM_BITS-1:0] sx, sy;
    logic signed [SUM_BITS-1:0] qx_s, qy_s;
    logic signed [PRED_BITS-1:0] px, py;
    logic signed [DIFF_BITS-1:0] ex_now, ey_now;

    function automatic logic [HADDR_BITS-1:0] hist_addr(
        input logic [TRK_BITS-1:0] trk,
        input logic [HD_BITS-1:0]  slot
    );
        hist_addr = HADDR_BITS'(trk) * HADDR_BITS'(HIST_DEPTH) + HADDR_BITS'(slot);
    endfunction

    function automatic logic [HD_BITS-1:0] ring_slot(
        input logic [HD_BITS-1:0] head,
        input logic [HD_BITS-1:0] ofs
    );
        logic [HD_BITS:0] s;
        s = (HD_BITS+1)'(head) + (HD_BITS+1)'(ofs);
        if (s >= (HD_BITS+1)'(HIST_DEPTH))
        begin
            s = s - (HD_BITS+1)'(HIST_DEPTH);
        end
        ring_slot = s[HD_BITS-1:0];
    endfunction

    function automatic logic [DEN_BITS-1:0] weight_sum(input logic [LEN_BITS-1:0] n);
        logic [2*LEN_BITS-1:0] p;
        p = (2*LEN_BITS)'(n) * (2*LEN_BITS)'(n - LEN_BITS'(1));
        weight_sum = DEN_BITS'(p >> 1);
    endfunction

    ntm_squarer u_squarer (
        .clk (clk),
        .op  (sq_op),
        .sq  (sq)
    );

    ntm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x (div_num_x),
        .num_y (div_num_y),
        .den   (div_den),
        .done  (div_done),
        .quo_x (quo_x),
        .quo_y (quo_y)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign t_last    = (t_reg == TRK_BITS'(MAX_TRACKS - 1));
    assign cur_valid = valid_reg[t_reg];
    assign cur_miss  = valid_reg[t_reg] && !matched_reg[t_reg];
    assign miss_inc  = (miss_reg[t_reg] == MISS_MAX) ? MISS_MAX
                     : miss_reg[t_reg] + MISS_BITS'(1);
    assign cur_free  = cur_miss && (miss_inc >= miss_limit_reg);

    assign d2        = THR_BITS'(dx2_reg) + THR_BITS'(sq);
    assign better    = !best_found_reg || (d2 < best_reg);
    assign match_now = best_found_reg
                    && ({best_reg, 2'b00} < (THR_BITS+2)'(thr_reg));
    assign open_now  = !match_now && free_found_reg;
    assign push_head = (head_reg[best_t_reg] == '0) ? HD_BITS'(HIST_DEPTH - 1)
                     : head_reg[best_t_reg] - HD_BITS'(1);

    assign sx = signed'(SUM_BITS'(ACC_BITS'(n_reg) * ACC_BITS'(c0x_reg)))
              - signed'(SUM_BITS'(acc_x_reg));
    assign sy = signed'(SUM_BITS'(ACC_BITS'(n_reg) * ACC_BITS'(c0y_reg)))
              - signed'(SUM_BITS'(acc_y_reg));

    always_comb
    begin
        if (n_reg <= LEN_BITS'(1))
        begin
            qx_s = '0;
            qy_s = '0;
        end
        else
        begin
            qx_s = negx_reg ? -signed'(SUM_BITS'(quo_x)) : signed'(SUM_BITS'(quo_x));
            qy_s = negy_reg ? -signed'(SUM_BITS'(quo_y)) : signed'(SUM_BITS'(quo_y));
        end
    end

    assign px = signed'(pred_rd_reg[PRED_BITS-1:0]);
    assign py = signed'(pred_rd_reg[2*PRED_BITS-1:PRED_BITS]);
    assign ex_now = signed'(DIFF_BITS'(cx_reg)) - DIFF_BITS'(px);
    assign ey_now = signed'(DIFF_BITS'(cy_reg)) - DIFF_BITS'(py);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (kind)
                        KIND_FRAME_START: state_next = S_P_SCAN;
                        KIND_DETECTION:   state_next = S_D_W;
                        KIND_FRAME_END:   state_next = S_E_SCAN;
                        default:          state_next = S_FINISH;
                    endcase
                end
            end
            S_P_SCAN:
            begin
                if (cur_valid)
                begin
                    state_next = S_P_ADDR;
                end
                else if (t_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_P_ADDR:     state_next = S_P_ACC;
            S_P_ACC:
            begin
                if ((j_reg + LEN_BITS'(1)) == n_reg)
                begin
                    state_next = S_P_DIV_GO;
                end
                else
                begin
                    state_next = S_P_ADDR;
                end
            end
            S_P_DIV_GO:
            begin
                state_next = (n_reg <= LEN_BITS'(1)) ? S_P_WRITE : S_P_DIV_WAIT;
            end
            S_P_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_P_WRITE;
                end
            end
            S_P_WRITE:    state_next = t_last ? S_FINISH : S_P_SCAN;
            S_D_W:        state_next = S_D_H;
            S_D_H:        state_next = S_D_THR;
            S_D_THR:      state_next = S_D_SCAN;
            S_D_SCAN:
            begin
                if (cur_valid)
                begin
                    state_next = S_D_EX;
                end
                else if (t_last)
                begin
                    state_next = S_D_DECIDE;
                end
            end
            S_D_EX:       state_next = S_D_EY;
            S_D_EY:       state_next = S_D_CMP;
            S_D_CMP:      state_next = t_last ? S_D_DECIDE : S_D_SCAN;
            S_D_DECIDE:   state_next = S_FINISH;
            S_E_SCAN:     state_next = t_last ? S_FINISH : S_E_SCAN;
            S_FINISH:     state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        t_inc      = 1'b0;
        sq_op      = ex_now;
        div_start  = 1'b0;
        div_num_x  = NUM_BITS'(sx[SUM_BITS-1] ? -sx : sx);
        div_num_y  = NUM_BITS'(sy[SUM_BITS-1] ? -sy : sy);
        div_den    = weight_sum(n_reg);
        hist_raddr = hist_addr(t_reg, ring_slot(head_reg[t_reg], j_reg[HD_BITS-1:0]));
        hist_we    = 1'b0;
        hist_waddr = hist_addr(best_t_reg, push_head);
        hist_wdata = {cy_reg, cx_reg};
        pred_raddr = t_reg;
        pred_we    = 1'b0;
        pred_waddr = t_reg;
        pred_wdata = {PRED_BITS'(SUM_BITS'(c0y_reg) + qy_s),
                      PRED_BITS'(SUM_BITS'(c0x_reg) + qx_s)};
        unique case (state_reg)
            S_P_SCAN:     t_inc = !cur_valid && !t_last;
            S_P_DIV_GO:   div_start = (n_reg > LEN_BITS'(1));
            S_P_WRITE:
            begin
                pred_we = 1'b1;
                t_inc   = !t_last;
            end
            S_D_W:        sq_op = signed'(DIFF_BITS'(w_reg));
            S_D_H:        sq_op = signed'(DIFF_BITS'(h_reg));
            S_D_SCAN:     t_inc = !cur_valid && !t_last;
            S_D_EY:       sq_op = ey_reg;
            S_D_CMP:      t_inc = !t_last;
            S_D_DECIDE:
            begin
                if (match_now)
                begin
                    hist_we = 1'b1;
                end
                else if (open_now)
                begin
                    hist_we    = 1'b1;
                    hist_waddr = hist_addr(free_t_reg, '0);
                    pred_we    = 1'b1;
                    pred_waddr = free_t_reg;
                    pred_wdata = {PRED_BITS'(cy_reg), PRED_BITS'(cx_reg)};
                end
            end
            S_E_SCAN:     t_inc = !t_last;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            t_reg          <= '0;
            done_reg       <= 1'b0;
            miss_limit_reg <= MISS_LIMIT_RESET;
            live_reg       <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            for (int i = 0; i < MAX_TRACKS; i++)
            begin
                valid_reg[i]   <= 1'b0;
                len_reg[i]     <= '0;
                matched_reg[i] <= 1'b0;
                miss_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
            if (miss_limit_we)
            begin
                miss_limit_reg <= miss_limit_data;
            end
            if (accept)
            begin
                t_reg          <= '0;
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
                if (kind == KIND_FRAME_START)
                begin
                    for (int i = 0; i < MAX_TRACKS; i++)
                    begin
                        matched_reg[i] <= 1'b0;
                    end
                end
            end
            else if (t_inc)
            begin
                t_reg <= t_reg + TRK_BITS'(1);
            end
            if (state_reg == S_D_SCAN && !cur_valid)
            begin
                free_found_reg <= 1'b1;
            end
            if (state_reg == S_D_CMP)
            begin
                best_found_reg <= 1'b1;
            end
            if (state_reg == S_D_DECIDE)
            begin
                if (match_now)
                begin
                    matched_reg[best_t_reg] <= 1'b1;
                    if (len_reg[best_t_reg] < LEN_BITS'(HIST_DEPTH))
                    begin
                        len_reg[best_t_reg] <= len_reg[best_t_reg] + LEN_BITS'(1);
                    end
                end
                else if (open_now)
                begin
                    valid_reg[free_t_reg]   <= 1'b1;
                    len_reg[free_t_reg]     <= LEN_BITS'(1);
                    matched_reg[free_t_reg] <= 1'b1;
                    miss_reg[free_t_reg]    <= '0;
                    live_reg                <= live_reg + LIVE_BITS'(1);
                end
            end
            if (state_reg == S_E_SCAN && cur_miss)
            begin
                miss_reg[t_reg] <= miss_inc;
                if (cur_free)
                begin
                    valid_reg[t_reg] <= 1'b0;
                    len_reg[t_reg]   <= '0;
                    live_reg         <= live_reg - LIVE_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cx_reg       <= center_x;
                    cy_reg       <= center_y;
                    w_reg        <= box_width;
                    h_reg        <= box_height;
                    idx_out_reg  <= '0;
                    new_out_reg  <= 1'b0;
                    drop_out_reg <= 1'b0;
                    removed_reg  <= '0;
                end
            end
            S_P_SCAN:
            begin
                n_reg     <= len_reg[t_reg];
                j_reg     <= '0;
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            S_P_ACC:
            begin
                acc_x_reg <= acc_x_reg + ACC_BITS'(hist_rd_reg[COORD_BITS-1:0]);
                acc_y_reg <= acc_y_reg + ACC_BITS'(hist_rd_reg[2*COORD_BITS-1:COORD_BITS]);
                if (j_reg == '0)
                begin
                    c0x_reg <= hist_rd_reg[COORD_BITS-1:0];
                    c0y_reg <= hist_rd_reg[2*COORD_BITS-1:COORD_BITS];
                end
                j_reg <= j_reg + LEN_BITS'(1);
            end
            S_P_DIV_GO:
            begin
                negx_reg <= sx[SUM_BITS-1];
                negy_reg <= sy[SUM_BITS-1];
            end
            S_D_H:        thr_reg <= THR_BITS'(sq);
            S_D_THR:      thr_reg <= thr_reg + THR_BITS'(sq);
            S_D_SCAN:
            begin
                if (!cur_valid && !free_found_reg)
                begin
                    free_t_reg <= t_reg;
                end
            end
            S_D_EX:       ey_reg  <= ey_now;
            S_D_EY:       dx2_reg <= sq;
            S_D_CMP:
            begin
                if (better)
                begin
                    best_reg   <= d2;
                    best_t_reg <= t_reg;
                end
            end
            S_D_DECIDE:
            begin
                if (match_now)
                begin
                    head_reg[best_t_reg] <= push_head;
                    idx_out_reg          <= best_t_reg;
                end
                else if (open_now)
                begin
                    head_reg[free_t_reg] <= '0;
                    idx_out_reg          <= free_t_reg;
                    new_out_reg          <= 1'b1;
                end
                else
                begin
                    drop_out_reg <= 1'b1;
                end
            end
            S_E_SCAN:
            begin
                if (cur_free)
                begin
                    removed_reg <= removed_reg + LIVE_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pred_we)
        begin
            pred_mem[pred_waddr] <= pred_wdata;
        end
        pred_rd_reg <= pred_mem[pred_raddr];
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign track_index   = IDX_OUT_BITS'(idx_out_reg);
    assign is_new        = new_out_reg;
    assign dropped       = drop_out_reg;
    assign live_tracks   = LIVE_OUT_BITS'(live_reg);
    assign removed_count = LIVE_OUT_BITS'(removed_reg);

endmodule

FILE: bench/nearest_track_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_track_matcher_tb
// Self-checking bench for the nearest track matcher. A scoreboard keeps its
// own copy of the track table, predicts the result word of every accepted
// word and compares it field by field with the done strobe. Stimulus is a
// short directed sequence followed by frames of moving objects with noise,
// broken frames and changes of the miss limit.
// ----------------------------------------------------------------------------
module nearest_track_matcher_tb;
    import ntm_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int WORD_GOAL  = 1725;
    localparam int MAX_OBJS   = 40;

    typedef struct {
        logic [IDX_OUT_BITS-1:0]  track_index;
        logic                     is_new;
        logic                     dropped;
        logic [LIVE_OUT_BITS-1:0] live_tracks;
        logic [LIVE_OUT_BITS-1:0] removed_count;
    } match_result_t;

    class track_scoreboard;
        int            limit_now;
        bit            live[MAX_TRACKS];
        int            hist_x[MAX_TRACKS][HIST_DEPTH];
        int            hist_y[MAX_TRACKS][HIST_DEPTH];
        int            hist_len[MAX_TRACKS];
        int            pred_x[MAX_TRACKS];
        int            pred_y[MAX_TRACKS];
        bit            hit[MAX_TRACKS];
        int            misses[MAX_TRACKS];
        match_result_t expected_q[$];
        int            errors;

        function new();
            limit_now = MISS_LIMIT_RESET;
            errors = 0;
            for (int t = 0; t < MAX_TRACKS; t++)
            begin
                live[t] = 1'b0;
                hist_len[t] = 0;
                hit[t] = 1'b0;
                misses[t] = 0;
                pred_x[t] = 0;
                pred_y[t] = 0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(logic [KIND_BITS-1:0] k, int cx, int cy, int w, int h);
            match_result_t r;
            int            t;
            int            j;
            int            n;
            int            wgt;
            int            wsum;
            int            dx;
            int            dy;
            int            best_t;
            int            free_t;
            int            removed;
            int            count;
            longint        ex;
            longint        ey;
            longint        d2;
            longint        best;
            r = '{track_index: '0, is_new: 1'b0, dropped: 1'b0,
                  live_tracks: '0, removed_count: '0};
            removed = 0;
            if (k == KIND_FRAME_START)
            begin
                for (t = 0; t < MAX_TRACKS; t++)
                begin
                    hit[t] = 1'b0;
                    if (live[t])
                    begin
                        n = (hist_len[t] > HIST_DEPTH) ? HIST_DEPTH : hist_len[t];
                        dx = 0;
                        dy = 0;
                        wsum = 0;
                        for (j = 1; j < n; j++)
                        begin
                            wgt = n - j;
                            dx += (hist_x[t][j-1] - hist_x[t][j]) * wgt;
                            dy += (hist_y[t][j-1] - hist_y[t][j]) * wgt;
                            wsum += wgt;
                        end
                        if (wsum > 0)
                        begin
                            dx = dx / wsum;
                            dy = dy / wsum;
                        end
                        pred_x[t] = hist_x[t][0] + dx;
                        pred_y[t] = hist_y[t][0] + dy;
                    end
                end
            end
            else if (k == KIND_DETECTION)
            begin
                best_t = -1;
                best = 0;
                for (t = 0; t < MAX_TRACKS; t++)
                begin
                    if (live[t])
                    begin
                        ex = longint'(cx) - pred_x[t];
                        ey = longint'(cy) - pred_y[t];
                        d2 = ex * ex + ey * ey;
                        if (best_t < 0 || d2 < best)
                        begin
                            best = d2;
                            best_t = t;
                        end
                    end
                end
                if (best_t >= 0 && 4 * best < longint'(w) * w + longint'(h) * h)
                begin
                    for (j = HIST_DEPTH - 1; j > 0; j--)
                    begin
                        hist_x[best_t][j] = hist_x[best_t][j-1];
                        hist_y[best_t][j] = hist_y[best_t][j-1];
                    end
                    hist_x[best_t][0] = cx;
                    hist_y[best_t][0] = cy;
                    if (hist_len[best_t] < HIST_DEPTH)
                        hist_len[best_t]++;
                    hit[best_t] = 1'b1;
                    r.track_index = best_t[IDX_OUT_BITS-1:0];
                end
                else
                begin
                    free_t = -1;
                    for (t = 0; t < MAX_TRACKS; t++)
                        if (!live[t] && free_t < 0)
                            free_t = t;
                    if (free_t < 0)
                    begin
                        r.dropped = 1'b1;
                    end
                    else
                    begin
                        live[free_t] = 1'b1;
                        hist_x[free_t][0] = cx;
                        hist_y[free_t][0] = cy;
                        hist_len[free_t] = 1;
                        pred_x[free_t] = cx;
                        pred_y[free_t] = cy;
                        hit[free_t] = 1'b1;
                        misses[free_t] = 0;
                        r.track_index = free_t[IDX_OUT_BITS-1:0];
                        r.is_new = 1'b1;
                    end
                end
            end
            else if (k == KIND_FRAME_END)
            begin
                for (t = 0; t < MAX_TRACKS; t++)
                begin
                    if (live[t] && !hit[t])
                    begin
                        if (misses[t] < int'(MISS_MAX))
                            misses[t]++;
                        if (misses[t] >= limit_now)
                        begin
                            live[t] = 1'b0;
                            hist_len[t] = 0;
                            removed++;
                        end
                    end
                end
            end
            count = 0;
            for (t = 0; t < MAX_TRACKS; t++)
                if (live[t])
                    count++;
            r.live_tracks = count[LIVE_OUT_BITS-1:0];
            r.removed_count = removed[LIVE_OUT_BITS-1:0];
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_word(match_result_t got);
            match_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected word idx=%0d new=%0d drop=%0d live=%0d rem=%0d",
                             got.track_index, got.is_new, got.dropped,
                             got.live_tracks, got.removed_count);
                return;
            end
            e = expected_q.pop_front();
            if (got.track_index !== e.track_index || got.is_new !== e.is_new ||
                got.dropped !== e.dropped || got.live_tracks !== e.live_tracks ||
                got.removed_count !== e.removed_count)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: expected idx=%0d new=%0d drop=%0d live=%0d rem=%0d",
                             e.track_index, e.is_new, e.dropped, e.live_tracks,
                             e.removed_count);
                    $display("       got      idx=%0d new=%0d drop=%0d live=%0d rem=%0d",
                             got.track_index, got.is_new, got.dropped,
                             got.live_tracks, got.removed_count);
                end
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [KIND_BITS-1:0]     kind = '0;
    logic [COORD_BITS-1:0]    center_x = '0;
    logic [COORD_BITS-1:0]    center_y = '0;
    logic [COORD_BITS-1:0]    box_width = '0;
    logic [COORD_BITS-1:0]    box_height = '0;
    logic                     miss_limit_we = 1'b0;
    logic [MISS_BITS-1:0]     miss_limit_data = '0;
    logic                     done;
    logic [IDX_OUT_BITS-1:0]  track_index;
    logic                     is_new;
    logic                     dropped;
    logic [LIVE_OUT_BITS-1:0] live_tracks;
    logic [LIVE_OUT_BITS-1:0] removed_count;

    track_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              words_sent = 0;

    nearest_track_matcher u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .center_x        (center_x),
        .center_y        (center_y),
        .box_width       (box_width),
        .box_height      (box_height),
        .miss_limit_we   (miss_limit_we),
        .miss_limit_data (miss_limit_data),
        .done            (done),
        .track_index     (track_index),
        .is_new          (is_new),
        .dropped         (dropped),
        .live_tracks     (live_tracks),
        .removed_count   (removed_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word('{track_index: track_index, is_new: is_new, dropped: dropped,
                            live_tracks: live_tracks, removed_count: removed_count});
    end

    task automatic send_word(input logic [KIND_BITS-1:0] k, input int cx, input int cy,
                             input int w, input int h);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        center_x   <= COORD_BITS'(cx);
        center_y   <= COORD_BITS'(cy);
        box_width  <= COORD_BITS'(w);
        box_height <= COORD_BITS'(h);
        do
            @(posedge clk);
        while (busy);
        sb.note_word(k, cx, cy, w, h);
        words_sent++;
    endtask

    task automatic set_miss_limit(input int v);
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        @(negedge clk);
        miss_limit_we   <= 1'b1;
        miss_limit_data <= MISS_BITS'(v);
        sb.limit_now = v;
        @(negedge clk);
        miss_limit_we <= 1'b0;
    endtask

    initial
    begin
        #50_000_000;
        $display("nearest_track_matcher test failed");
        $finish;
    end

    initial
    begin
        int obj_x[MAX_OBJS];
        int obj_y[MAX_OBJS];
        int obj_vx[MAX_OBJS];
        int obj_vy[MAX_OBJS];
        int phase;
        int lim;
        int n_obj;
        int n_frames;
        int flaw;
        int px;
        int py;
        int waited;
        phase = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, field extremes, zero box, tie, unknown kind,
        // then misses piling up until the default limit frees tracks.
        send_word(KIND_FRAME_END, 0, 0, 0, 0);
        send_word(KIND_FRAME_START, 0, 0, 0, 0);
        send_word(KIND_DETECTION, 0, 0, 1, 1);
        send_word(KIND_DETECTION, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_word(KIND_DETECTION, 0, 0, 0, 0);
        send_word(KIND_DETECTION, 1, 1, COORD_MAX, COORD_MAX);
        send_word(KIND_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_word(KIND_FRAME_END, 0, 0, 0, 0);
        send_word(KIND_FRAME_START, 0, 0, 0, 0);
        send_word(KIND_DETECTION, 3, 3, 2, 2);
        send_word(KIND_DETECTION, 2, 2, 2, 2);
        send_word(KIND_FRAME_END, 0, 0, 0, 0);
        repeat (5)
        begin
            send_word(KIND_FRAME_START, 0, 0, 0, 0);
            send_word(KIND_FRAME_END, 0, 0, 0, 0);
        end

        while (words_sent < WORD_GOAL)
        begin
            case (phase)
                0: lim = 15;
                1: lim = 0;
                2: lim = 1;
                default: lim = $urandom_range(0, 15);
            endcase
            set_miss_limit(lim);
            n_obj = (phase % 3 == 0) ? 36 : $urandom_range(1, 12);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < n_obj; i++)
            begin
                obj_x[i] = $urandom_range(0, COORD_MAX);
                obj_y[i] = $urandom_range(0, COORD_MAX);
                obj_vx[i] = int'($urandom_range(0, 40)) - 20;
                obj_vy[i] = int'($urandom_range(0, 40)) - 20;
            end
            n_frames = $urandom_range(6, 14);
            for (int f = 0; f < n_frames && words_sent < WORD_GOAL; f++)
            begin
                flaw = $urandom_range(0, 19);
                if (flaw != 0)
                    send_word(KIND_FRAME_START, $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), 0, 0);
                for (int i = 0; i < n_obj; i++)
                begin
                    if ($urandom_range(0, 9) != 0)
                    begin
                        px = obj_x[i] + int'($urandom_range(0, 4)) - 2;
                        py = obj_y[i] + int'($urandom_range(0, 4)) - 2;
                        px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
                        py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
                        send_word(KIND_DETECTION, px, py, $urandom_range(8, 300),
                                  $urandom_range(8, 300));
                    end
                    obj_x[i] += obj_vx[i];
                    obj_y[i] += obj_vy[i];
                    if (obj_x[i] < 0 || obj_x[i] > COORD_MAX || obj_y[i] < 0 ||
                        obj_y[i] > COORD_MAX || $urandom_range(0, 29) == 0)
                    begin
                        obj_x[i] = $urandom_range(0, COORD_MAX);
                        obj_y[i] = $urandom_range(0, COORD_MAX);
                    end
                end
                if ($urandom_range(0, 2) == 0)
                    send_word(KIND_DETECTION, $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX));
                if ($urandom_range(0, 9) == 0)
                    send_word(KIND_UNUSED, $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX));
                if (flaw != 1)
                    send_word(KIND_FRAME_END, $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), 0, 0);
            end
            phase++;
        end

        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (sb.pending() > 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() > 0)
        begin
            sb.errors++;
            $display("ERROR: %0d result words never arrived", sb.pending());
        end
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("nearest_track_matcher test passed");
        else
            $display("nearest_track_matcher test failed");
        $finish;
    end

endmodule
